[design/sensor_segment_reassembly_unit_defines.svh]
// Assertion macros for the sensor segment reassembly unit
`ifndef SENSOR_SEGMENT_REASSEMBLY_UNIT_DEFINES_SVH
`define SENSOR_SEGMENT_REASSEMBLY_UNIT_DEFINES_SVH

// Check a property on every rising edge outside reset
`define SSRU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset cycles included
`define SSRU_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ssru_pkg.sv]
// Shared types, constants and byte helpers of the segment reassembly unit
package ssru_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int BLOB_CAP      = 64;
    localparam int WORD_IDX_W    = 3;
    localparam int DATA_W        = 64;
    localparam int SIZE_W        = 7;
    localparam int SID_OUT_W     = 4;
    localparam int COUNT_W       = 5;
    localparam int MASK_W        = 16;
    localparam int SEQ_W         = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFERED_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOB_SIZE     = 2'd2;

    localparam logic [SIZE_W-1:0] BLOB_SIZE_RESET = 7'd8;
    localparam logic [SIZE_W-1:0] BLOB_CAP_SIZE   = SIZE_W'(BLOB_CAP);

    typedef enum logic [1:0] {
        OP_FWD,
        OP_STORE,
        OP_STORE_EMIT
    } t_op_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_back_state;

    // One classified segment on its way from front to back
    typedef struct packed {
        t_op_kind                  kind;
        logic [SID_OUT_W-1:0]      sid;
        logic [7:0]                ev;
        logic [SIZE_W-1:0]         size;
        logic [WORD_IDX_W-1:0]     word;
        logic [PAYLOAD_BYTES-1:0]  byte_en;
        logic [DATA_W-1:0]         data;
        logic [WORD_IDX_W-1:0]     last_idx;
    } t_op;

    // Bytes of a given blob word that lie below the blob size
    function automatic logic [PAYLOAD_BYTES-1:0] byte_keep(input logic [WORD_IDX_W-1:0] word,
                                                           input logic [SIZE_W-1:0] size);
        logic [PAYLOAD_BYTES-1:0] keep;
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            keep[b] = {1'b0, word, 3'(b)} < size;
        end
        return keep;
    endfunction

    // Expand a byte mask to a bit mask
    function automatic logic [DATA_W-1:0] byte_bits(input logic [PAYLOAD_BYTES-1:0] keep);
        logic [DATA_W-1:0] bits;
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            bits[8*b +: 8] = {8{keep[b]}};
        end
        return bits;
    endfunction

endpackage

[design/ssru_front.sv]
// Front end: configuration registers, sequence tracking and segment classification
module ssru_front #(
    parameter int MAX_SENSORS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ssru_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ssru_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_sensor_id,
    input  logic [7:0]                        i_event_type,
    input  logic [ssru_pkg::SEQ_W-1:0]        i_segment_seq,
    input  logic                              i_last_segment,
    input  logic [ssru_pkg::DATA_W-1:0]       i_payload,
    output logic                              o_push,
    output ssru_pkg::t_op                     o_push_op,
    input  logic                              i_full
);

    localparam int SID_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam logic [ssru_pkg::COUNT_W-1:0] MAX_COUNT = ssru_pkg::COUNT_W'(MAX_SENSORS);

    logic [ssru_pkg::COUNT_W-1:0] r_sensor_count;
    logic [ssru_pkg::MASK_W-1:0]  r_buffered_mask;
    logic [ssru_pkg::SIZE_W-1:0]  r_blob_size;
    logic [ssru_pkg::SEQ_W-1:0]   r_exp_seq [MAX_SENSORS];

    logic [ssru_pkg::SIZE_W-1:0]  eff_size;
    logic [ssru_pkg::SIZE_W-1:0]  size_m1;
    logic [ssru_pkg::COUNT_W-1:0] eff_count;
    logic [SID_W-1:0]             sid;
    logic                         known;
    logic                         buffered;
    logic                         seq_ok;
    logic                         in_blob;
    logic                         accept;
    logic [ssru_pkg::SEQ_W-1:0]   n_exp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_count  <= '0;
            r_buffered_mask <= '0;
            r_blob_size     <= ssru_pkg::BLOB_SIZE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ssru_pkg::REG_SENSOR_COUNT:  r_sensor_count  <= i_cfg_data[ssru_pkg::COUNT_W-1:0];
                ssru_pkg::REG_BUFFERED_MASK: r_buffered_mask <= i_cfg_data[ssru_pkg::MASK_W-1:0];
                ssru_pkg::REG_BLOB_SIZE:     r_blob_size     <= i_cfg_data[ssru_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_size = r_blob_size;
        if (r_blob_size == '0) begin
            eff_size = 7'd1;
        end else if (r_blob_size > ssru_pkg::BLOB_CAP_SIZE) begin
            eff_size = ssru_pkg::BLOB_CAP_SIZE;
        end
        size_m1   = eff_size - 7'd1;
        eff_count = (r_sensor_count > MAX_COUNT) ? MAX_COUNT : r_sensor_count;
        known     = i_sensor_id < {3'b000, eff_count};
        sid       = i_sensor_id[SID_W-1:0];
        buffered  = r_buffered_mask[i_sensor_id[3:0]];
        seq_ok    = i_segment_seq == r_exp_seq[sid];
        in_blob   = i_segment_seq[ssru_pkg::SEQ_W-1:ssru_pkg::WORD_IDX_W] == '0;
        // out-of-order or final segments restart the sequence
        n_exp     = (!seq_ok || i_last_segment) ? '0 : i_segment_seq + 8'd1;
    end

    always_comb begin
        o_push_op.kind     = !buffered ? ssru_pkg::OP_FWD
                           : (i_last_segment ? ssru_pkg::OP_STORE_EMIT : ssru_pkg::OP_STORE);
        o_push_op.sid      = i_sensor_id[ssru_pkg::SID_OUT_W-1:0];
        o_push_op.ev       = i_event_type;
        o_push_op.size     = eff_size;
        o_push_op.word     = i_segment_seq[ssru_pkg::WORD_IDX_W-1:0];
        o_push_op.byte_en  = in_blob ? ssru_pkg::byte_keep(i_segment_seq[ssru_pkg::WORD_IDX_W-1:0],
                                                           eff_size)
                                     : '0;
        o_push_op.data     = buffered ? i_payload
                           : i_payload & ssru_pkg::byte_bits(ssru_pkg::byte_keep('0, eff_size));
        o_push_op.last_idx = size_m1[5:3];
    end

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_push     = accept && known && (buffered ? seq_ok : i_last_segment);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_SENSORS; s++) begin
                r_exp_seq[s] <= '0;
            end
        end else if (accept && known && buffered) begin
            r_exp_seq[sid] <= n_exp;
        end
    end

endmodule

[design/ssru_queue.sv]
// Short queue of classified segments between front and back
module ssru_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssru_pkg::t_op  i_push_op,
    output logic           o_full,
    output logic           o_valid,
    output ssru_pkg::t_op  o_head,
    input  logic           i_pop
);

    localparam int PTR_W = (ssru_pkg::QUEUE_DEPTH > 1) ? $clog2(ssru_pkg::QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(ssru_pkg::QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   FULL_CNT  = (PTR_W + 1)'(ssru_pkg::QUEUE_DEPTH);

    ssru_pkg::t_op    r_slot [ssru_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = r_count == FULL_CNT;
    assign o_valid = r_count != '0;
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[design/ssru_back.sv]
// Back end: blob memory, chunk sequencer and output register
`include "sensor_segment_reassembly_unit_defines.svh"

module ssru_back #(
    parameter int MAX_SENSORS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  ssru_pkg::t_op                      i_q_head,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ssru_pkg::SID_OUT_W-1:0]     o_out_sensor_id,
    output logic [7:0]                         o_out_event_type,
    output logic [ssru_pkg::SIZE_W-1:0]        o_data_size,
    output logic [ssru_pkg::WORD_IDX_W-1:0]    o_chunk_index,
    output logic [ssru_pkg::DATA_W-1:0]        o_chunk_data,
    output logic                               o_last_chunk
);

    localparam int SID_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
    localparam int ROWS  = MAX_SENSORS * (1 << ssru_pkg::WORD_IDX_W);
    localparam int ROW_W = SID_W + ssru_pkg::WORD_IDX_W;

    logic [ssru_pkg::DATA_W-1:0]       r_mem [ROWS];
    logic [ROWS-1:0]                   r_row_valid;
    logic [ssru_pkg::DATA_W-1:0]       r_rd_data;
    logic                              r_rd_vld;

    ssru_pkg::t_back_state             r_state;
    ssru_pkg::t_back_state             n_state;
    ssru_pkg::t_op                     r_cur;
    logic [ssru_pkg::WORD_IDX_W-1:0]   r_idx;
    logic [ssru_pkg::WORD_IDX_W-1:0]   n_idx;

    logic                              r_out_valid;
    logic [ssru_pkg::SID_OUT_W-1:0]    r_out_sid;
    logic [7:0]                        r_out_ev;
    logic [ssru_pkg::SIZE_W-1:0]       r_out_size;
    logic [ssru_pkg::WORD_IDX_W-1:0]   r_out_idx;
    logic [ssru_pkg::DATA_W-1:0]       r_out_data;
    logic                              r_out_last;

    logic                              out_free;
    logic                              load_fwd;
    logic                              load_chunk;
    logic                              rd_en;
    logic [ROW_W-1:0]                  rd_row;
    logic                              wr_en;
    logic [ROW_W-1:0]                  wr_row;
    logic [ssru_pkg::PAYLOAD_BYTES-1:0] wr_keep;
    logic [ssru_pkg::DATA_W-1:0]       wr_data;
    logic [ssru_pkg::DATA_W-1:0]       chunk_data;
    logic                              at_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign at_last  = r_idx == r_cur.last_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssru_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_pop      = 1'b0;
        load_fwd   = 1'b0;
        load_chunk = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        rd_row     = {r_cur.sid[SID_W-1:0], r_idx};
        unique case (r_state)
            ssru_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_head.kind == ssru_pkg::OP_FWD) begin
                        if (out_free) begin
                            o_pop    = 1'b1;
                            load_fwd = 1'b1;
                        end
                    end else begin
                        o_pop = 1'b1;
                        wr_en = |i_q_head.byte_en;
                        if (i_q_head.kind == ssru_pkg::OP_STORE_EMIT) begin
                            n_state = ssru_pkg::ST_READ;
                            n_idx   = '0;
                        end
                    end
                end
            end
            ssru_pkg::ST_READ: begin
                rd_en   = 1'b1;
                n_state = ssru_pkg::ST_EMIT;
            end
            ssru_pkg::ST_EMIT: begin
                if (out_free) begin
                    load_chunk = 1'b1;
                    if (at_last) begin
                        n_state = ssru_pkg::ST_IDLE;
                    end else begin
                        // prefetch the next chunk while this one goes out
                        n_idx  = r_idx + 1'b1;
                        rd_en  = 1'b1;
                        rd_row = {r_cur.sid[SID_W-1:0], n_idx};
                    end
                end
            end
            default: n_state = ssru_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (o_pop) begin
            r_cur <= i_q_head;
        end
    end

    // A row never written reads as zero: fill its unwritten bytes with zero on first write
    assign wr_row  = {i_q_head.sid[SID_W-1:0], i_q_head.word};
    assign wr_keep = r_row_valid[wr_row] ? i_q_head.byte_en : '1;
    assign wr_data = i_q_head.data & ssru_pkg::byte_bits(i_q_head.byte_en);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            for (int b = 0; b < ssru_pkg::PAYLOAD_BYTES; b++) begin
                if (wr_keep[b]) begin
                    r_mem[wr_row][8*b +: 8] <= wr_data[8*b +: 8];
                end
            end
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_valid[wr_row] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_row_valid[rd_row];
            end
        end
    end

    assign chunk_data = (r_rd_vld ? r_rd_data : '0)
                      & ssru_pkg::byte_bits(ssru_pkg::byte_keep(r_idx, r_cur.size));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_fwd || load_chunk) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_fwd) begin
            r_out_sid  <= i_q_head.sid;
            r_out_ev   <= i_q_head.ev;
            r_out_size <= i_q_head.size;
            r_out_idx  <= '0;
            r_out_data <= i_q_head.data;
            r_out_last <= 1'b1;
        end else if (load_chunk) begin
            r_out_sid  <= r_cur.sid;
            r_out_ev   <= r_cur.ev;
            r_out_size <= r_cur.size;
            r_out_idx  <= r_idx;
            r_out_data <= chunk_data;
            r_out_last <= at_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_sensor_id  = r_out_sid;
    assign o_out_event_type = r_out_ev;
    assign o_data_size      = r_out_size;
    assign o_chunk_index    = r_out_idx;
    assign o_chunk_data     = r_out_data;
    assign o_last_chunk     = r_out_last;

    `SSRU_ASSERT(a_pop_needs_item, i_clk, i_rst_n, o_pop |-> i_q_valid, "pop from empty queue")
    `SSRU_ASSERT(a_busy_no_pop, i_clk, i_rst_n, (r_state != ssru_pkg::ST_IDLE) |-> !o_pop, "pop while emitting")
    `SSRU_ASSERT(a_last_ends_event, i_clk, i_rst_n, (r_state == ssru_pkg::ST_EMIT && out_free && at_last) |=> (r_state == ssru_pkg::ST_IDLE && o_out_valid && o_last_chunk), "final chunk did not end event")
    `SSRU_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

[design/sensor_segment_reassembly_unit.sv]
// Top level of the sensor segment reassembly unit
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one sensor segment per item.
//   Output channel (o_out_valid / i_out_stall) delivers event chunks, eight
//   bytes each, last_chunk set on the final chunk of an event.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes sensor_count,
//   buffered_mask and blob_size; write only while the unit is idle.
// Flow:
//   The front classifies a segment in the cycle it is accepted and drops
//   unknown or out-of-order segments and non-final unbuffered ones there.
//   Kept segments enter a two-entry queue. The back stores a buffered
//   segment or loads a forwarded payload into the output register; a final
//   segment of a buffered sensor is written, read back from the blob memory
//   and sent out chunk by chunk while the next chunk is prefetched.
//   A forward passes the queue and the output register; a blob passes the
//   queue, the write, read and emit states and the output register.
// Reset clears sensor_count, buffered_mask, sequence numbers and row valid
// bits, sets blob_size to 8; the blob store then reads as zero. A stalled
// receiver holds the output register; the queue fills and o_in_stall rises.
module sensor_segment_reassembly_unit #(
    parameter int MAX_SENSORS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ssru_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ssru_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_sensor_id,
    input  logic [7:0]                        i_event_type,
    input  logic [ssru_pkg::SEQ_W-1:0]        i_segment_seq,
    input  logic                              i_last_segment,
    input  logic [ssru_pkg::DATA_W-1:0]       i_payload,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ssru_pkg::SID_OUT_W-1:0]    o_out_sensor_id,
    output logic [7:0]                        o_out_event_type,
    output logic [ssru_pkg::SIZE_W-1:0]       o_data_size,
    output logic [ssru_pkg::WORD_IDX_W-1:0]   o_chunk_index,
    output logic [ssru_pkg::DATA_W-1:0]       o_chunk_data,
    output logic                              o_last_chunk
);

    logic          q_push;
    ssru_pkg::t_op q_push_op;
    logic          q_full;
    logic          q_valid;
    ssru_pkg::t_op q_head;
    logic          q_pop;

    ssru_front #(
        .MAX_SENSORS(MAX_SENSORS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sensor_id    (i_sensor_id),
        .i_event_type   (i_event_type),
        .i_segment_seq  (i_segment_seq),
        .i_last_segment (i_last_segment),
        .i_payload      (i_payload),
        .o_push         (q_push),
        .o_push_op      (q_push_op),
        .i_full         (q_full)
    );

    ssru_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_push_op (q_push_op),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_head    (q_head),
        .i_pop     (q_pop)
    );

    ssru_back #(
        .MAX_SENSORS(MAX_SENSORS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_head         (q_head),
        .o_pop            (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_sensor_id  (o_out_sensor_id),
        .o_out_event_type (o_out_event_type),
        .o_data_size      (o_data_size),
        .o_chunk_index    (o_chunk_index),
        .o_chunk_data     (o_chunk_data),
        .o_last_chunk     (o_last_chunk)
    );

endmodule
